// ===== sv/assert_macros.svh =====
// assertion macros shared by the estimator rtl
// relies on i_clk and i_rst_n being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PNCNFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PNCNFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pncnfe_pkg.sv =====
// types, constants and helpers for the pn correlated noise floor estimator
// no dependencies
package pncnfe_pkg;

    localparam int SAMPLE_WIDTH_DEF = 8;
    localparam int ACC_WIDTH        = 16;
    localparam int LEVEL_WIDTH      = 16;
    localparam int FRAC_BITS        = 8;
    localparam int NOISE_WIDTH      = LEVEL_WIDTH + FRAC_BITS;
    localparam int CODE_WIDTH       = 14;
    localparam int REQ_WIDTH        = 2;
    localparam int CFG_IDX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH   = 2;
    localparam int SMOOTH_WIDTH     = 2;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_WIDTH  = $clog2(QUEUE_DEPTH);

    localparam logic [CODE_WIDTH-1:0] CODE_MASK_FULL  = 14'h03ff;
    localparam logic [CODE_WIDTH-1:0] CODE_MASK_TRUNC = 14'h3fff;
    localparam logic [CODE_WIDTH-1:0] CODE_END_FULL   = 14'h03ff;
    localparam logic [CODE_WIDTH-1:0] CODE_END_TRUNC  = 14'h0ade;

    localparam logic [LEVEL_WIDTH-1:0] NOISE_INIT_FULL  = 16'd784;
    localparam logic [LEVEL_WIDTH-1:0] NOISE_INIT_TRUNC = 16'd1920;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_ACC     = 2'd0,
        REQ_SHIFT   = 2'd1,
        REQ_LOAD    = 2'd2,
        REQ_RESTART = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_CODE_MODE = 2'd0,
        REG_SMOOTH    = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic                   is_acc;
        logic                   is_shift;
        logic                   is_load;
        logic                   is_restart;
        logic [ACC_WIDTH-1:0]   re;
        logic [ACC_WIDTH-1:0]   im;
        logic [LEVEL_WIDTH-1:0] load_val;
    } t_req;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    function automatic logic [NOISE_WIDTH-1:0] noise_init(input logic mode);
        logic [LEVEL_WIDTH-1:0] lvl;
        lvl = mode ? NOISE_INIT_TRUNC : NOISE_INIT_FULL;
        return {lvl, {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic [ACC_WIDTH-1:0] magnitude(input logic [ACC_WIDTH-1:0] a);
        return a[ACC_WIDTH-1] ? ~a : a;
    endfunction

endpackage

// ===== sv/pncnfe_in_if.sv =====
// input channel of the estimator: valid/ready handshake with request payload
// depends on pncnfe_pkg
interface pncnfe_in_if #(
    parameter int SAMPLE_WIDTH = pncnfe_pkg::SAMPLE_WIDTH_DEF
);
    logic                                      valid;
    logic                                      ready;
    logic [pncnfe_pkg::REQ_WIDTH-1:0]          req_type;
    logic signed [SAMPLE_WIDTH-1:0]            sample_real;
    logic signed [SAMPLE_WIDTH-1:0]            sample_imag;
    logic [pncnfe_pkg::LEVEL_WIDTH-1:0]        noise_value;

    modport source (output valid, req_type, sample_real, sample_imag, noise_value,
                    input ready);
    modport sink (input valid, req_type, sample_real, sample_imag, noise_value,
                  output ready);
endinterface

// ===== sv/pncnfe_out_if.sv =====
// output channel of the estimator: valid/ready handshake with noise result
// depends on pncnfe_pkg
interface pncnfe_out_if;
    logic                               valid;
    logic                               ready;
    logic [pncnfe_pkg::LEVEL_WIDTH-1:0] noise_level;
    logic                               epoch_end;

    modport source (output valid, noise_level, epoch_end, input ready);
    modport sink (input valid, noise_level, epoch_end, output ready);
endinterface

// ===== sv/pncnfe_front.sv =====
// front end: accepts items, decodes the request type and widens samples
// depends on pncnfe_pkg and pncnfe_in_if
module pncnfe_front #(
    parameter int SAMPLE_WIDTH = pncnfe_pkg::SAMPLE_WIDTH_DEF
) (
    pncnfe_in_if.sink              i_in,
    input  pncnfe_pkg::t_fifo_stat i_fifo_stat,
    output logic                   o_push,
    output pncnfe_pkg::t_req       o_req
);

    assign i_in.ready = ~i_fifo_stat.full;
    assign o_push     = i_in.valid & ~i_fifo_stat.full;

    always_comb begin
        o_req            = '0;
        o_req.re         = pncnfe_pkg::ACC_WIDTH'(i_in.sample_real);
        o_req.im         = pncnfe_pkg::ACC_WIDTH'(i_in.sample_imag);
        o_req.load_val   = i_in.noise_value;
        case (pncnfe_pkg::t_req_type'(i_in.req_type))
            pncnfe_pkg::REQ_ACC:     o_req.is_acc     = 1'b1;
            pncnfe_pkg::REQ_SHIFT:   o_req.is_shift   = 1'b1;
            pncnfe_pkg::REQ_LOAD:    o_req.is_load    = 1'b1;
            pncnfe_pkg::REQ_RESTART: o_req.is_restart = 1'b1;
            default:                 o_req.is_restart = 1'b1;
        endcase
    end

endmodule

// ===== sv/pncnfe_fifo.sv =====
// short queue of decoded requests between front and back
// depends on pncnfe_pkg
module pncnfe_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pncnfe_pkg::t_req       i_req,
    input  logic                   i_pop,
    output pncnfe_pkg::t_req       o_req,
    output pncnfe_pkg::t_fifo_stat o_stat
);

    localparam int PW = pncnfe_pkg::QUEUE_PTR_WIDTH;

    pncnfe_pkg::t_req r_mem [pncnfe_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count, n_count;

    assign o_req        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (PW+1)'(pncnfe_pkg::QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

// ===== sv/pncnfe_back.sv =====
// back end: code generator, correlator, amplitude and noise smoothing pipeline
// depends on pncnfe_pkg and pncnfe_out_if
module pncnfe_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pncnfe_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [pncnfe_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  pncnfe_pkg::t_fifo_stat                i_fifo_stat,
    input  pncnfe_pkg::t_req                      i_req,
    output logic                                  o_pop,
    pncnfe_out_if.source                          o_out
);

    localparam int AW = pncnfe_pkg::ACC_WIDTH;
    localparam int CW = pncnfe_pkg::CODE_WIDTH;
    localparam int LW = pncnfe_pkg::LEVEL_WIDTH;
    localparam int NW = pncnfe_pkg::NOISE_WIDTH;

    logic                                 r_mode, n_mode;
    logic [pncnfe_pkg::SMOOTH_WIDTH-1:0]  r_smooth, n_smooth;
    logic [CW-1:0]                        r_code, n_code;
    logic [AW-1:0]                        r_acc_re, n_acc_re;
    logic [AW-1:0]                        r_acc_im, n_acc_im;
    logic [NW-1:0]                        r_noise, n_noise;

    logic          r_s1_valid, n_s1_valid;
    logic          r_s1_end, n_s1_end;
    logic          r_s1_load, n_s1_load;
    logic          r_s1_restart, n_s1_restart;
    logic [AW-1:0] r_s1_mag_re, n_s1_mag_re;
    logic [AW-1:0] r_s1_mag_im, n_s1_mag_im;
    logic [LW-1:0] r_s1_load_val, n_s1_load_val;

    logic          r_s2_valid, n_s2_valid;
    logic          r_s2_end, n_s2_end;
    logic          r_s2_load, n_s2_load;
    logic          r_s2_restart, n_s2_restart;
    logic [AW-1:0] r_s2_amp, n_s2_amp;
    logic [LW-1:0] r_s2_load_val, n_s2_load_val;

    logic          r_out_valid, n_out_valid;
    logic          r_out_end, n_out_end;

    logic                 adv;
    logic [CW-1:0]        code_mask;
    logic [CW-1:0]        code_end;
    logic                 code_neg;
    logic                 code_fb;
    logic [CW-1:0]        code_step;
    logic                 seq_end;
    logic [AW-1:0]        big, little;
    logic [AW+1:0]        little_x3;
    logic signed [AW:0]   diff;
    logic signed [AW:0]   step;
    logic [NW-1:0]        noise_sum;

    assign adv   = ~r_out_valid | o_out.ready;
    assign o_pop = adv & ~i_fifo_stat.empty;

    assign o_out.valid       = r_out_valid;
    assign o_out.noise_level = r_noise[NW-1 -: LW];
    assign o_out.epoch_end   = r_out_end;

    // code generator and correlator
    always_comb begin
        code_mask = r_mode ? pncnfe_pkg::CODE_MASK_TRUNC : pncnfe_pkg::CODE_MASK_FULL;
        code_end  = r_mode ? pncnfe_pkg::CODE_END_TRUNC : pncnfe_pkg::CODE_END_FULL;
        code_neg  = r_mode ? r_code[13] : r_code[9];
        code_fb   = r_mode ? (r_code[13] ^ r_code[7] ^ r_code[5] ^ r_code[0])
                           : (r_code[9] ^ r_code[2]);
        code_step = {r_code[CW-2:0], code_fb} & code_mask;
        seq_end   = (code_step == code_end);
    end

    // amplitude estimate
    always_comb begin
        if (r_s1_mag_re < r_s1_mag_im) begin
            big    = r_s1_mag_im;
            little = r_s1_mag_re;
        end else begin
            big    = r_s1_mag_re;
            little = r_s1_mag_im;
        end
        little_x3 = {1'b0, little, 1'b0} + {2'b00, little};
    end

    // smoothing step, shift rounds toward minus infinity
    always_comb begin
        diff      = $signed({1'b0, r_s2_amp}) - $signed({1'b0, r_noise[NW-1 -: LW]});
        step      = diff >>> {r_smooth, 1'b0};
        noise_sum = r_noise + NW'(step);
    end

    always_comb begin
        n_mode        = r_mode;
        n_smooth      = r_smooth;
        n_code        = r_code;
        n_acc_re      = r_acc_re;
        n_acc_im      = r_acc_im;
        n_noise       = r_noise;
        n_s1_valid    = r_s1_valid;
        n_s1_end      = r_s1_end;
        n_s1_load     = r_s1_load;
        n_s1_restart  = r_s1_restart;
        n_s1_mag_re   = r_s1_mag_re;
        n_s1_mag_im   = r_s1_mag_im;
        n_s1_load_val = r_s1_load_val;
        n_s2_valid    = r_s2_valid;
        n_s2_end      = r_s2_end;
        n_s2_load     = r_s2_load;
        n_s2_restart  = r_s2_restart;
        n_s2_amp      = r_s2_amp;
        n_s2_load_val = r_s2_load_val;
        n_out_valid   = r_out_valid;
        n_out_end     = r_out_end;

        if (adv) begin
            // stage one
            n_s1_valid    = o_pop;
            n_s1_end      = 1'b0;
            n_s1_load     = i_req.is_load;
            n_s1_restart  = i_req.is_restart;
            n_s1_mag_re   = pncnfe_pkg::magnitude(r_acc_re);
            n_s1_mag_im   = pncnfe_pkg::magnitude(r_acc_im);
            n_s1_load_val = i_req.load_val;
            if (o_pop) begin
                if (i_req.is_acc) begin
                    if (code_neg) begin
                        n_acc_re = r_acc_re - i_req.re;
                        n_acc_im = r_acc_im - i_req.im;
                    end else begin
                        n_acc_re = r_acc_re + i_req.re;
                        n_acc_im = r_acc_im + i_req.im;
                    end
                end
                if (i_req.is_shift) begin
                    if (seq_end) begin
                        n_s1_end = 1'b1;
                        n_code   = code_mask;
                        n_acc_re = '0;
                        n_acc_im = '0;
                    end else begin
                        n_code = code_step;
                    end
                end
                if (i_req.is_restart) begin
                    n_code   = code_mask;
                    n_acc_re = '0;
                    n_acc_im = '0;
                end
            end

            // stage two
            n_s2_valid    = r_s1_valid;
            n_s2_end      = r_s1_end;
            n_s2_load     = r_s1_load;
            n_s2_restart  = r_s1_restart;
            n_s2_load_val = r_s1_load_val;
            if (big > little_x3[AW-1:0] || little_x3[AW+1:AW] != 2'b00) begin
                n_s2_amp = (little_x3[AW+1:AW] != 2'b00) ? big - (big >> 3) + (little >> 1)
                                                         : big + (little >> 3);
            end else begin
                n_s2_amp = big - (big >> 3) + (little >> 1);
            end

            // result stage
            n_out_valid = r_s2_valid;
            n_out_end   = r_s2_valid & r_s2_end;
            if (r_s2_valid) begin
                if (r_s2_end) begin
                    n_noise = noise_sum;
                end
                if (r_s2_load) begin
                    n_noise = {r_s2_load_val, {pncnfe_pkg::FRAC_BITS{1'b0}}};
                end
                if (r_s2_restart) begin
                    n_noise = pncnfe_pkg::noise_init(r_mode);
                end
            end
        end

        if (i_cfg_we) begin
            case (pncnfe_pkg::t_cfg_reg'(i_cfg_idx))
                pncnfe_pkg::REG_CODE_MODE: begin
                    n_mode   = i_cfg_data[0];
                    n_code   = i_cfg_data[0] ? pncnfe_pkg::CODE_MASK_TRUNC
                                             : pncnfe_pkg::CODE_MASK_FULL;
                    n_acc_re = '0;
                    n_acc_im = '0;
                    n_noise  = pncnfe_pkg::noise_init(i_cfg_data[0]);
                end
                pncnfe_pkg::REG_SMOOTH: begin
                    n_smooth = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_smooth    <= '0;
            r_code      <= pncnfe_pkg::CODE_MASK_FULL;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_noise     <= pncnfe_pkg::noise_init(1'b0);
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_end   <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_smooth    <= n_smooth;
            r_code      <= n_code;
            r_acc_re    <= n_acc_re;
            r_acc_im    <= n_acc_im;
            r_noise     <= n_noise;
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
            r_out_end   <= n_out_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_end      <= n_s1_end;
        r_s1_load     <= n_s1_load;
        r_s1_restart  <= n_s1_restart;
        r_s1_mag_re   <= n_s1_mag_re;
        r_s1_mag_im   <= n_s1_mag_im;
        r_s1_load_val <= n_s1_load_val;
        r_s2_end      <= n_s2_end;
        r_s2_load     <= n_s2_load;
        r_s2_restart  <= n_s2_restart;
        r_s2_amp      <= n_s2_amp;
        r_s2_load_val <= n_s2_load_val;
    end

endmodule

// ===== sv/pn_correlated_noise_floor_estimator.sv =====
// top level of the pn correlated noise floor estimator
// depends on pncnfe_pkg, the channel interfaces, front, fifo, back and assert_macros.svh
//
// Takes one item per clock while the queue has room and gives exactly one result
// per item. An item is accepted whenever the four-entry request queue has room, so
// the input side keeps running while a result waits at the output. When nothing
// stalls, the accepting edge writes the queue, then the item passes the registered
// code/correlator stage, the amplitude stage and the noise stage in turn before its
// result is presented. The noise stage holds the smoothed noise and the result
// register, and a stalled output freezes the three back stages together while the
// queue absorbs up to four more items.
// Configuration writes are taken at any time but are meant for an idle block;
// writing code_mode restarts the code, the accumulators and the noise value.
`include "assert_macros.svh"

module pn_correlated_noise_floor_estimator #(
    parameter int SAMPLE_WIDTH = pncnfe_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pncnfe_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [pncnfe_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    pncnfe_in_if.sink                             i_in,
    pncnfe_out_if.source                          o_out
);

    logic                   push;
    logic                   pop;
    pncnfe_pkg::t_req       push_req;
    pncnfe_pkg::t_req       head_req;
    pncnfe_pkg::t_fifo_stat fifo_stat;
    logic                   mode_wr;
    logic                   noise_at_init;

    pncnfe_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_in        (i_in),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_req       (push_req)
    );

    pncnfe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_stat  (fifo_stat)
    );

    pncnfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_fifo_stat (fifo_stat),
        .i_req       (head_req),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    assign mode_wr       = i_cfg_we && (i_cfg_idx == pncnfe_pkg::REG_CODE_MODE);
    assign noise_at_init = (o_out.noise_level == pncnfe_pkg::NOISE_INIT_FULL) ||
                           (o_out.noise_level == pncnfe_pkg::NOISE_INIT_TRUNC);

    `PNCNFE_ASSERT(a_queue_state, !(fifo_stat.full && fifo_stat.empty), "queue full and empty")
    `PNCNFE_ASSERT(a_pop_nonempty, !(pop && fifo_stat.empty), "pop from empty queue")
    `PNCNFE_ASSERT_NEXT(a_mode_restart, mode_wr, noise_at_init, "mode write did not restart noise")

endmodule
